// ----- rtl/gdd_pkg.sv -----
// ----------------------------------------------------------------------------
// Gregorian date decrement: shared definitions
// Request kinds, calendar constants, the job record passed from the front
// end to the stepping unit, and the month length and leap-year helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package gdd_pkg;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = 1;

    typedef enum logic [1:0] {
        REQ_DAY   = 2'd0,
        REQ_WEEK  = 2'd1,
        REQ_MONTH = 2'd2,
        REQ_YEAR  = 2'd3
    } t_req_kind;

    localparam logic [4:0]  DAY_FIRST      = 5'd1;
    localparam logic [4:0]  DAY_LAST_DEC   = 5'd31;
    localparam logic [4:0]  DAY_FEB_LEAP   = 5'd29;
    localparam logic [4:0]  DAY_FEB_COMMON = 5'd28;
    localparam logic [3:0]  MONTH_JAN      = 4'd1;
    localparam logic [3:0]  MONTH_FEB      = 4'd2;
    localparam logic [3:0]  MONTH_DEC      = 4'd12;
    localparam logic [15:0] YEAR_MIN       = 16'h8000;

    // Year is biased by a multiple of 400 so the remainder search works on
    // a nonnegative value.
    localparam logic [16:0] YEAR_BIAS      = 17'd32800;
    localparam logic [16:0] CYCLE_YEARS    = 17'd400;
    localparam logic [2:0]  RED_FIRST      = 3'd7;
    localparam logic [8:0]  REM_LAST       = 9'd399;
    localparam logic [8:0]  REM_AFTER_WRAP = 9'd367;
    localparam logic [8:0]  REM_C1         = 9'd100;
    localparam logic [8:0]  REM_C2         = 9'd200;
    localparam logic [8:0]  REM_C3         = 9'd300;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic        month_mode;
        logic [17:0] cnt;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
        logic [8:0]  rem;
    } t_job;

    // The remainder is the year modulo 400, taken as a nonnegative value.
    function automatic logic is_leap(input logic [8:0] rem);
        return (rem[1:0] == 2'b00) && (rem != REM_C1) && (rem != REM_C2) &&
               (rem != REM_C3);
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        if (month == MONTH_FEB) begin
            len = leap ? DAY_FEB_LEAP : DAY_FEB_COMMON;
        end else if ((month >= MONTH_JAN) && (month <= MONTH_DEC)) begin
            len = MONTH_LEN[month - MONTH_JAN];
        end else begin
            len = DAY_LAST_DEC;
        end
        return len;
    endfunction

    // Remainder after the year drops by one, including the wrap of the
    // most negative year to the most positive one.
    function automatic logic [8:0] rem_dec(input logic [8:0] rem, input logic [15:0] year);
        logic [8:0] res;
        if (year == YEAR_MIN) begin
            res = REM_AFTER_WRAP;
        end else if (rem == 9'd0) begin
            res = REM_LAST;
        end else begin
            res = rem - 9'd1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/gdd_ifs.sv -----
// ----------------------------------------------------------------------------
// Gregorian date decrement: channel interfaces
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface gdd_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [4:0]         in_day;
    logic [3:0]         in_month;
    logic signed [15:0] in_year;
    logic [14:0]        amount;

    modport source (output valid, req_type, in_day, in_month, in_year, amount,
                    input ready);
    modport sink (input valid, req_type, in_day, in_month, in_year, amount,
                  output ready);
endinterface

interface gdd_rsp_if;
    logic               valid;
    logic               ready;
    logic [4:0]         out_day;
    logic [3:0]         out_month;
    logic signed [15:0] out_year;

    modport source (output valid, out_day, out_month, out_year, input ready);
    modport sink (input valid, out_day, out_month, out_year, output ready);
endinterface

`default_nettype wire

// ----- rtl/gdd_front.sv -----
// ----------------------------------------------------------------------------
// Gregorian date decrement: front end
// Accepts a request, normalizes the date, works out the step count and
// finds the year modulo 400 by a shift-and-subtract search.
// ----------------------------------------------------------------------------
`default_nettype none

module gdd_front
    import gdd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    gdd_req_if.sink    i_req,
    output logic       o_job_valid,
    input  wire        i_job_ready,
    output t_job       o_job
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_RED  = 3'b010,
        F_PUSH = 3'b100
    } t_front_state;

    t_front_state r_state, n_state;
    t_job         r_job, n_job;
    logic [16:0]  r_acc, n_acc;
    logic [2:0]   r_k, n_k;
    logic [16:0]  sub_val;
    logic [17:0]  amt_ext;

    assign i_req.ready = (r_state == F_IDLE);
    assign o_job_valid = (r_state == F_PUSH);
    assign sub_val     = CYCLE_YEARS << r_k;
    assign amt_ext     = {3'b000, i_req.amount};

    always_comb begin
        o_job     = r_job;
        o_job.rem = r_acc[8:0];
    end

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_acc   = r_acc;
        n_k     = r_k;
        case (r_state)
            F_IDLE: begin
                if (i_req.valid) begin
                    n_state = F_RED;
                    n_k     = RED_FIRST;
                    n_acc   = {i_req.in_year[15], i_req.in_year} + YEAR_BIAS;
                    n_job.day = (i_req.in_day == 5'd0) ? DAY_FIRST : i_req.in_day;
                    if (i_req.in_month == 4'd0) begin
                        n_job.month = MONTH_JAN;
                    end else if (i_req.in_month > MONTH_DEC) begin
                        n_job.month = MONTH_DEC;
                    end else begin
                        n_job.month = i_req.in_month;
                    end
                    n_job.year       = i_req.in_year;
                    n_job.rem        = 9'd0;
                    n_job.month_mode = 1'b0;
                    case (t_req_kind'(i_req.req_type))
                        REQ_DAY: begin
                            n_job.cnt = amt_ext;
                        end
                        REQ_WEEK: begin
                            n_job.cnt = (amt_ext << 3) - amt_ext;
                        end
                        REQ_MONTH: begin
                            n_job.cnt        = amt_ext;
                            n_job.month_mode = 1'b1;
                        end
                        default: begin
                            n_job.cnt  = 18'd0;
                            n_job.year = i_req.in_year - {1'b0, i_req.amount};
                        end
                    endcase
                end
            end
            F_RED: begin
                if (r_acc >= sub_val) begin
                    n_acc = r_acc - sub_val;
                end
                n_k = r_k - 3'd1;
                if (r_k == 3'd0) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (i_job_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_acc <= n_acc;
        r_k   <= n_k;
    end

endmodule

`default_nettype wire

// ----- rtl/gdd_queue.sv -----
// ----------------------------------------------------------------------------
// Gregorian date decrement: job queue
// Small register FIFO that decouples the front end from the stepping unit.
// ----------------------------------------------------------------------------
`default_nettype none

module gdd_queue
    import gdd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push_valid,
    output logic       o_push_ready,
    input  t_job       i_push_job,
    output logic       o_pop_valid,
    input  wire        i_pop_ready,
    output t_job       o_pop_job
);

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, n_wr;
    logic [Q_AW-1:0] r_rd, n_rd;
    logic [Q_AW:0]   r_cnt, n_cnt;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_cnt != (Q_AW + 1)'(Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_job    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr  = push ? r_wr + 1'b1 : r_wr;
        n_rd  = pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gdd_back.sv -----
// ----------------------------------------------------------------------------
// Gregorian date decrement: stepping unit
// Takes jobs from the queue and applies one day or month step per cycle,
// then places the date in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gdd_back
    import gdd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_job_valid,
    output logic       o_job_ready,
    input  t_job       i_job,
    gdd_rsp_if.source  o_rsp
);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_RUN  = 2'b10
    } t_back_state;

    t_back_state r_state, n_state;
    t_job        r_job, n_job;
    t_job        step_job;
    logic        r_out_valid, n_out_valid;
    logic [4:0]  r_out_day, n_out_day;
    logic [3:0]  r_out_month, n_out_month;
    logic [15:0] r_out_year, n_out_year;
    logic        out_free;
    logic        leap;
    logic [3:0]  prev_month;
    logic [4:0]  len_prev;

    assign o_job_ready     = (r_state == B_IDLE);
    assign out_free        = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.out_day   = r_out_day;
    assign o_rsp.out_month = r_out_month;
    assign o_rsp.out_year  = r_out_year;

    assign leap       = is_leap(r_job.rem);
    assign prev_month = r_job.month - 4'd1;
    assign len_prev   = days_in(prev_month, leap);

    always_comb begin
        step_job     = r_job;
        step_job.cnt = r_job.cnt - 18'd1;
        if (r_job.month_mode) begin
            if (r_job.month == MONTH_JAN) begin
                step_job.month = MONTH_DEC;
                step_job.year  = r_job.year - 16'd1;
                step_job.rem   = rem_dec(r_job.rem, r_job.year);
            end else begin
                step_job.month = prev_month;
                if (r_job.day > len_prev) begin
                    step_job.day = len_prev;
                end
            end
        end else if (r_job.day <= DAY_FIRST) begin
            if (r_job.month == MONTH_JAN) begin
                step_job.day   = DAY_LAST_DEC;
                step_job.month = MONTH_DEC;
                step_job.year  = r_job.year - 16'd1;
                step_job.rem   = rem_dec(r_job.rem, r_job.year);
            end else begin
                step_job.month = prev_month;
                step_job.day   = len_prev;
            end
        end else begin
            step_job.day = r_job.day - 5'd1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_day   = r_out_day;
        n_out_month = r_out_month;
        n_out_year  = r_out_year;
        case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    n_job   = i_job;
                    n_state = B_RUN;
                end
            end
            B_RUN: begin
                if (r_job.cnt == 18'd0) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_day   = r_job.day;
                        n_out_month = r_job.month;
                        n_out_year  = r_job.year;
                        n_state     = B_IDLE;
                    end
                end else begin
                    n_job = step_job;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job       <= n_job;
        r_out_day   <= n_out_day;
        r_out_month <= n_out_month;
        r_out_year  <= n_out_year;
    end

endmodule

`default_nettype wire

// ----- rtl/gregorian_date_decrement.sv -----
// Step count: the amount for day and month requests, seven times it for week
// requests, and zero for year requests, which the front end applies at once.
// The front end can take a new request while the stepping unit still works
// through an earlier job; the queue holds the jobs in between.
// Reset: synchronous, active low; clears the queue, both controllers and the output valid flag.
// ----------------------------------------------------------------------------
// Gregorian date decrement: top level
// Moves a date back by days, weeks, months or years, through a front end,
// a job queue and a stepping unit.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_decrement
    import gdd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    gdd_req_if.sink    i_req,
    gdd_rsp_if.source  o_rsp
);

    logic front_valid;
    logic front_ready;
    t_job front_job;
    logic q_valid;
    logic q_ready;
    t_job q_job;

    gdd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready),
        .o_job       (front_job)
    );

    gdd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_job   (front_job),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_job    (q_job)
    );

    gdd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .i_job       (q_job),
        .o_rsp       (o_rsp)
    );

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.out_month >= MONTH_JAN) && (o_rsp.out_month <= MONTH_DEC))
        else $error("response month out of range");

    a_day_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.out_day != 5'd0))
        else $error("response day is zero");

    a_job_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid |-> (q_job.month >= MONTH_JAN) && (q_job.month <= MONTH_DEC))
        else $error("queued job carries an unnormalized month");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid && !q_valid)
        else $error("response or queue valid right after reset");

endmodule

`default_nettype wire

// ----- tb/tb_gregorian_date_decrement.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date decrement: testbench
// Sends a short table of directed requests and then random ones, under
// varying sender and receiver idle patterns and one long receiver hold-off.
// Each response field is checked against a table row or behavioral predictor.
// ----------------------------------------------------------------------------

module tb_gregorian_date_decrement
    import gdd_pkg::*;
;

    localparam int NUM_DIR      = 26;
    localparam int NUM_RAND     = 1624;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 150000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [4:0] CAL_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [4:0]         day;
        logic [3:0]         month;
        logic signed [15:0] year;
    } t_cal_date;

    typedef struct packed {
        t_req_kind          kind;
        logic [4:0]         day;
        logic [3:0]         month;
        logic signed [15:0] year;
        logic [14:0]        amount;
    } t_dec_req;

    typedef struct packed {
        t_dec_req  rq;
        logic      typed;
        t_cal_date want;
    } t_dec_row;

    logic i_clk;
    logic i_rst_n;

    gdd_req_if req_if ();
    gdd_rsp_if rsp_if ();

    gregorian_date_decrement u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_cal_date pending_dates [$];
    int        error_count   = 0;
    int        send_idle_pct = 26;
    int        rcv_idle_pct  = 56;
    bit        hold_request  = 1'b0;
    int        hold_left     = 0;
    int        quiet_cycles  = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic leap_year(input logic signed [15:0] yr);
        int mag;
        mag = (yr < 0) ? -int'(yr) : int'(yr);
        return (mag % 4 == 0) && ((mag % 100 != 0) || (mag % 400 == 0));
    endfunction

    function automatic logic [4:0] month_days(input logic signed [15:0] yr,
                                              input logic [3:0] mon);
        if (mon == MONTH_FEB) begin
            return leap_year(yr) ? 5'd29 : 5'd28;
        end
        return CAL_LEN[mon - 4'd1];
    endfunction

    function automatic t_cal_date date_minus(input t_dec_req rq);
        t_cal_date dt;
        int        steps;
        int        i;
        dt.day   = (rq.day == 5'd0) ? 5'd1 : rq.day;
        dt.month = (rq.month == 4'd0) ? 4'd1 : ((rq.month > 4'd12) ? 4'd12 : rq.month);
        dt.year  = rq.year;
        case (rq.kind)
            REQ_DAY, REQ_WEEK: begin
                steps = (rq.kind == REQ_WEEK) ? int'(rq.amount) * 7 : int'(rq.amount);
                for (i = 0; i < steps; i++) begin
                    if (dt.day <= 5'd1) begin
                        if (dt.month == 4'd1) begin
                            dt.day   = 5'd31;
                            dt.month = 4'd12;
                            dt.year  = dt.year - 16'sd1;
                        end else begin
                            dt.month = dt.month - 4'd1;
                            dt.day   = month_days(dt.year, dt.month);
                        end
                    end else begin
                        dt.day = dt.day - 5'd1;
                    end
                end
            end
            REQ_MONTH: begin
                for (i = 0; i < int'(rq.amount); i++) begin
                    if (dt.month == 4'd1) begin
                        dt.month = 4'd12;
                        dt.year  = dt.year - 16'sd1;
                    end else begin
                        dt.month = dt.month - 4'd1;
                    end
                    if (dt.day > month_days(dt.year, dt.month)) begin
                        dt.day = month_days(dt.year, dt.month);
                    end
                end
            end
            default: begin
                dt.year = dt.year - $signed({1'b0, rq.amount});
            end
        endcase
        return dt;
    endfunction

    function automatic t_dec_row mk_row(input t_req_kind k, input int d, input int m,
                                        input int y, input int n, input bit typed,
                                        input int ed, input int em, input int ey);
        t_dec_row r;
        r.rq.kind    = k;
        r.rq.day     = d[4:0];
        r.rq.month   = m[3:0];
        r.rq.year    = y[15:0];
        r.rq.amount  = n[14:0];
        r.typed      = typed;
        r.want.day   = ed[4:0];
        r.want.month = em[3:0];
        r.want.year  = ey[15:0];
        return r;
    endfunction

    function automatic t_dec_req random_request();
        t_dec_req rq;
        int       v;
        rq.kind = t_req_kind'($urandom_range(0, 3));
        rq.day  = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 99) < 92) begin
            rq.month = 4'($urandom_range(1, 12));
        end else begin
            rq.month = 4'($urandom_range(0, 15));
        end
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(1600, 2400);
            2: v = $urandom_range(0, 1000) - 500;
            default: v = $urandom_range(0, 1) ? 32'h8000 + $urandom_range(0, 3)
                                               : 32'h7FFF - $urandom_range(0, 3);
        endcase
        rq.year = v[15:0];
        v = $urandom_range(0, 999);
        if (rq.kind == REQ_YEAR) begin
            rq.amount = 15'($urandom);
        end else if (rq.kind == REQ_WEEK) begin
            rq.amount = (v < 950) ? 15'($urandom_range(0, 10)) : 15'($urandom_range(11, 300));
        end else if (v < 800) begin
            rq.amount = 15'($urandom_range(0, 40));
        end else if (v < 990) begin
            rq.amount = 15'($urandom_range(41, 800));
        end else begin
            rq.amount = 15'($urandom);
        end
        return rq;
    endfunction

    task automatic offer_request(input t_dec_req rq, input t_cal_date want);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= rq.kind;
        req_if.in_day   <= rq.day;
        req_if.in_month <= rq.month;
        req_if.in_year  <= rq.year;
        req_if.amount   <= rq.amount;
        do @(posedge i_clk); while (!req_if.ready);
        pending_dates.push_back(want);
    endtask

    task automatic check_field(input string what, input logic signed [16:0] want,
                               input logic signed [16:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_cal_date want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_dates.size() == 0) begin
                error_count++;
                $display("%0t: unexpected transaction, expected none, actual %0d/%0d/%0d",
                         $time, rsp_if.out_day, rsp_if.out_month, rsp_if.out_year);
            end else begin
                want = pending_dates.pop_front();
                check_field("day", $signed({1'b0, want.day}), $signed({1'b0, rsp_if.out_day}));
                check_field("month", $signed({1'b0, want.month}),
                            $signed({1'b0, rsp_if.out_month}));
                check_field("year", want.year, rsp_if.out_year);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_dec_row dir_rows [NUM_DIR];
        t_dec_req rq;
        int       k;

        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_DAY;
        req_if.in_day   = 5'd0;
        req_if.in_month = 4'd0;
        req_if.in_year  = 16'sd0;
        req_if.amount   = 15'd0;
        rsp_if.ready    = 1'b0;

        dir_rows = '{
            mk_row(REQ_DAY,   15,  6,   2020,     0, 1, 15,  6,   2020),
            mk_row(REQ_DAY,    1,  1,   2000,     1, 1, 31, 12,   1999),
            mk_row(REQ_DAY,    1,  3,   2000,     1, 1, 29,  2,   2000),
            mk_row(REQ_DAY,    1,  3,   1900,     1, 1, 28,  2,   1900),
            mk_row(REQ_DAY,    1,  3,   2024,     1, 1, 29,  2,   2024),
            mk_row(REQ_DAY,    0,  0,    100,     0, 1,  1,  1,    100),
            mk_row(REQ_DAY,   31, 15,      5,     0, 1, 31, 12,      5),
            mk_row(REQ_DAY,    1,  1, -32768,     1, 1, 31, 12,  32767),
            mk_row(REQ_YEAR,  10,  5, -32768,     1, 1, 10,  5,  32767),
            mk_row(REQ_YEAR,  31,  2,      0, 32767, 1, 31,  2, -32767),
            mk_row(REQ_YEAR,   5,  5,  32767,     0, 1,  5,  5,  32767),
            mk_row(REQ_WEEK,   8,  1,   2021,     1, 1,  1,  1,   2021),
            mk_row(REQ_WEEK,   7,  1,   2021,     1, 1, 31, 12,   2020),
            mk_row(REQ_MONTH, 31,  3,   2021,     1, 1, 28,  2,   2021),
            mk_row(REQ_MONTH, 31,  3,   2000,     1, 1, 29,  2,   2000),
            mk_row(REQ_MONTH, 31,  5,   2021,     3, 0,  0,  0,      0),
            mk_row(REQ_MONTH, 15,  1,   2021,     1, 1, 15, 12,   2020),
            mk_row(REQ_MONTH, 31,  3,     -4,     1, 1, 29,  2,     -4),
            mk_row(REQ_DAY,    1,  3,   -100,     1, 1, 28,  2,   -100),
            mk_row(REQ_DAY,    1,  3,      0,     1, 1, 29,  2,      0),
            mk_row(REQ_DAY,   31,  2,   2021,    30, 0,  0,  0,      0),
            mk_row(REQ_MONTH, 20,  7,   1999,    12, 1, 20,  7,   1998),
            mk_row(REQ_DAY,   31, 12,  32767, 32767, 0,  0,  0,      0),
            mk_row(REQ_MONTH, 31, 12,     -1, 32767, 0,  0,  0,      0),
            mk_row(REQ_WEEK,  31, 15,    123,   100, 0,  0,  0,      0),
            mk_row(REQ_MONTH,  1,  1, -32768,     1, 1,  1, 12,  32767)
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (k = 0; k < NUM_DIR; k++) begin
            offer_request(dir_rows[k].rq,
                          dir_rows[k].typed ? dir_rows[k].want : date_minus(dir_rows[k].rq));
        end

        for (k = 0; k < NUM_RAND; k++) begin
            if (k == NUM_RAND / 3) begin
                send_idle_pct = 56;
                rcv_idle_pct  = 26;
            end else if (k == 2 * NUM_RAND / 3) begin
                send_idle_pct = 0;
                rcv_idle_pct  = 0;
                hold_request  = 1'b1;
            end
            rq = random_request();
            offer_request(rq, date_minus(rq));
        end

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/gdd_pkg.sv
rtl/gdd_ifs.sv
rtl/gdd_front.sv
rtl/gdd_queue.sv
rtl/gdd_back.sv
rtl/gregorian_date_decrement.sv
tb/tb_gregorian_date_decrement.sv
